// ===== sv/ifptc_pkg.sv =====
// shared types and constants for the imu frame parser with tilt check
package ifptc_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // position of the checksum byte, the last one of an 11-byte frame
  localparam logic [3:0] LAST_POS = 4'd10;

  // temperature: raw * 100 / 340 = raw * 5 / 17, the divide by 17 done by reciprocal
  localparam int unsigned TEMP_RECIP  = 246724;  // ceil(2^22 / 17)
  localparam int unsigned TEMP_SHIFT  = 22;
  localparam int unsigned TEMP_OFFSET = 3625;
  localparam int signed   TEMP_MIN    = -6012;
  localparam int signed   TEMP_MAX    = 13262;

  // register index, from paddr[2]
  localparam logic REG_LEFT  = 1'b0;
  localparam logic REG_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACC   = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TILT_OK    = 2'd0,
    TILT_LEFT  = 2'd1,
    TILT_RIGHT = 2'd2
  } tilt_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] temp_raw;
  } frame_t;

  typedef struct packed {
    logic [7:0] left_limit;
    logic [7:0] right_limit;
  } cfg_t;

endpackage

// ===== sv/ifptc_cfg_regs.sv =====
// apb configuration registers holding the tilt limits
module ifptc_cfg_regs import ifptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_limit  <= 8'd0;
      cfg.right_limit <= 8'd0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LEFT:  cfg.left_limit  <= pwdata[7:0];
        REG_RIGHT: cfg.right_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LEFT:  prdata = {24'd0, cfg.left_limit};
      REG_RIGHT: prdata = {24'd0, cfg.right_limit};
      default:   prdata = 32'd0;
    endcase
  end

  // paddr[1:0] only selects bytes within a word
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

// ===== sv/ifptc_frame_asm.sv =====
// byte assembler: collects 11-byte frames and registers each known frame
module ifptc_frame_asm import ifptc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       frame_take,
  output logic       frame_valid,
  output frame_t     frame
);

  logic [3:0] byte_index;
  logic [3:0] byte_index_next;
  logic [7:0] frame_bytes [1:9];
  logic       accept;
  logic       last;
  logic       known;
  kind_t      kind;

  assign in_ready = !frame_valid || frame_take;
  assign accept   = in_valid && in_ready;
  assign last     = (byte_index == LAST_POS);

  always_comb begin
    if (byte_index == 4'd0 && rx_byte != HDR_BYTE) begin
      byte_index_next = 4'd0;
    end else if (last) begin
      byte_index_next = 4'd0;
    end else begin
      byte_index_next = byte_index + 4'd1;
    end
  end

  always_comb begin
    known = 1'b1;
    kind  = KIND_ACC;
    case (frame_bytes[1])
      TYPE_ACC:   kind = KIND_ACC;
      TYPE_GYRO:  kind = KIND_GYRO;
      TYPE_ANGLE: kind = KIND_ANGLE;
      default:    known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 4'd0;
    end else if (accept) begin
      byte_index <= byte_index_next;
    end
  end

  // header and checksum bytes are not kept
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 1; k <= 9; k++) begin
        if (byte_index == 4'(k)) begin
          frame_bytes[k] <= rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (accept && last && known) begin
      frame_valid <= 1'b1;
    end else if (frame_take) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last && known) begin
      frame.kind     <= kind;
      frame.x        <= {frame_bytes[3], frame_bytes[2]};
      frame.y        <= {frame_bytes[5], frame_bytes[4]};
      frame.z        <= {frame_bytes[7], frame_bytes[6]};
      frame.temp_raw <= {frame_bytes[9], frame_bytes[8]};
    end
  end

endmodule

// ===== sv/ifptc_result_calc.sv =====
// result stage: temperature scaling, tilt compare and the output register
module ifptc_result_calc import ifptc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  input  frame_t             frame,
  input  cfg_t               cfg,
  output logic               frame_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         frame_kind,
  output logic signed [15:0] axis_x,
  output logic signed [15:0] axis_y,
  output logic signed [15:0] axis_z,
  output logic signed [14:0] temp_centi,
  output logic [1:0]         tilt_flag
);

  tilt_t              tilt_status;
  tilt_t              tilt_next;
  logic signed [16:0] raw_ext;
  logic [16:0]        mag;
  logic [17:0]        mag5;
  logic [35:0]        prod;
  logic [13:0]        quot;
  logic signed [14:0] temp_next;
  logic signed [24:0] scaled;
  logic signed [24:0] left_bound;
  logic signed [24:0] right_bound;

  assign frame_take = frame_valid && (!out_valid || out_ready);

  // truncation toward zero: divide the magnitude, then restore the sign
  always_comb begin
    raw_ext   = {frame.temp_raw[15], frame.temp_raw};
    mag       = frame.temp_raw[15] ? 17'(-raw_ext) : 17'(raw_ext);
    mag5      = 18'(mag) * 18'd5;
    prod      = 36'(mag5) * 36'(TEMP_RECIP);
    quot      = 14'(prod >> TEMP_SHIFT);
    temp_next = frame.temp_raw[15] ? 15'(TEMP_OFFSET) - 15'(quot)
                                   : 15'(TEMP_OFFSET) + 15'(quot);
  end

  // y * 180 against the limits scaled by 32768, exact
  always_comb begin
    scaled      = 25'($signed({{9{frame.y[15]}}, frame.y}) * 25'sd180);
    left_bound  = -$signed({2'b00, cfg.left_limit, 15'd0});
    right_bound = $signed({2'b00, cfg.right_limit, 15'd0});
    tilt_next   = tilt_status;
    if (frame.kind == KIND_ANGLE) begin
      if (scaled < left_bound) begin
        tilt_next = TILT_LEFT;
      end else if (scaled > right_bound) begin
        tilt_next = TILT_RIGHT;
      end else begin
        tilt_next = TILT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      tilt_status <= TILT_OK;
    end else begin
      if (frame_take) begin
        out_valid   <= 1'b1;
        tilt_status <= tilt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      frame_kind <= frame.kind;
      axis_x     <= frame.x;
      axis_y     <= frame.y;
      axis_z     <= frame.z;
      temp_centi <= temp_next;
      tilt_flag  <= tilt_next;
    end
  end

endmodule

// ===== sv/imu_frame_parser_tilt_check_unit.sv =====
// out_valid rises when the result register takes a frame completed by its checksum byte
// throughput: one byte per cycle unless stalled; frame and result regs decouple a stall
// the byte input stalls only while both the frame and result registers are full and out_ready is low
// the temperature path multiplies by 5 and by an 18x18 constant between two registers
// reset clears the byte position, the tilt state, both limits and the valid flags
// the frame buffer is not cleared; every byte is written before it is used
module imu_frame_parser_tilt_check_unit import ifptc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         frame_kind,
  output logic signed [15:0] axis_x,
  output logic signed [15:0] axis_y,
  output logic signed [15:0] axis_z,
  output logic signed [14:0] temp_centi,
  output logic [1:0]         tilt_flag,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t   cfg;
  frame_t frame;
  logic   frame_valid;
  logic   frame_take;

  ifptc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ifptc_frame_asm u_asm (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .frame_take  (frame_take),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  ifptc_result_calc u_calc (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .cfg         (cfg),
    .frame_take  (frame_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_kind  (frame_kind),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .axis_z      (axis_z),
    .temp_centi  (temp_centi),
    .tilt_flag   (tilt_flag)
  );

`ifndef SYNTH
  // input stalls only when the whole pipe is full and the output is held
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (frame_valid && out_valid && !out_ready))
    else $error("input stalled while the pipe can advance");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temp_centi >= 15'(TEMP_MIN) && temp_centi <= 15'(TEMP_MAX)))
    else $error("temperature out of range");

  // an angle frame past the right limit must have a positive y angle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind == KIND_ANGLE && tilt_flag == TILT_RIGHT) |-> (axis_y > 16'sd0))
    else $error("right tilt with non-positive y");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind == KIND_ANGLE && tilt_flag == TILT_LEFT) |-> (axis_y < 16'sd0))
    else $error("left tilt with non-negative y");
`endif

endmodule
